/* rtl/core/lsd_pkg.sv */
// ============================================================================
// lsd_pkg
// shared constants and types for the segment distance triplet pipeline
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lsd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int OUT_BITS       = 25;
    localparam int MUL_CHUNK      = 32;

    typedef struct packed {
        logic valid;
        logic degen;
        logic pzero;
    } t_flags;

endpackage

`default_nettype wire

/* rtl/core/lsd_dly.sv */
// ============================================================================
// lsd_dly
// fixed-depth delay line with shared advance enable
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lsd_dly #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_d
);

    logic [W-1:0] r_sh [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_sh[k] <= '0;
            end
        end else if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_d = r_sh[DEPTH-1];

endmodule

`default_nettype wire

/* rtl/core/lsd_mul.sv */
// ============================================================================
// lsd_mul
// unsigned multiplier split into 32x32-bit partial products, two stages
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lsd_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [AW-1:0]    i_a,
    input  wire logic [BW-1:0]    i_b,
    output logic      [AW+BW-1:0] o_p
);

    localparam int CH  = lsd_pkg::MUL_CHUNK;
    localparam int NA  = (AW + CH - 1) / CH;
    localparam int NB  = (BW + CH - 1) / CH;
    localparam int PAW = NA * CH;
    localparam int PBW = NB * CH;
    localparam int PW  = AW + BW;

    logic [PAW-1:0]    a_pad;
    logic [PBW-1:0]    b_pad;
    logic [2*CH-1:0]   r_pp [NA][NB];
    logic [PW-1:0]     n_p;
    logic [PW-1:0]     r_p;

    assign a_pad = PAW'(i_a);
    assign b_pad = PBW'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= a_pad[i*CH +: CH] * b_pad[j*CH +: CH];
                end
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_p = n_p + (PW'(r_pp[i][j]) << (CH * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* rtl/core/lsd_isq.sv */
// ============================================================================
// lsd_isq
// pipelined search for the largest q with q*q*d <= n, one bit per stage
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lsd_isq #(
    parameter int NW  = 158,
    parameter int DDW = 106,
    parameter int OB  = 25
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [NW-1:0]  i_n,
    input  wire logic [DDW-1:0] i_d,
    output logic      [OB-1:0]  o_q
);

    localparam int WW = (NW > DDW + 2*OB + 1) ? NW : DDW + 2*OB + 1;
    localparam int TW = DDW + OB;

    logic [WW-1:0]  r_rem [OB];
    logic [TW-1:0]  r_t   [OB];
    logic [DDW-1:0] r_d   [OB];
    logic [OB-1:0]  r_q   [OB+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= WW'(i_n);
            r_t[0]   <= '0;
            r_d[0]   <= i_d;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < OB; k++) begin : g_stage
        localparam int B = OB - 1 - k;
        logic [WW-1:0] n_cand;
        logic          n_take;

        always_comb begin
            n_cand = (WW'(r_t[k]) << (B + 1)) + (WW'(r_d[k]) << (2 * B));
            n_take = (n_cand <= r_rem[k]);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1] <= r_q[k] | (OB'(n_take) << B);
            end
        end

        if (k < OB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_take ? (r_rem[k] - n_cand) : r_rem[k];
                    r_t[k+1]   <= n_take ? (r_t[k] + (TW'(r_d[k]) << B)) : r_t[k];
                    r_d[k+1]   <= r_d[k];
                end
            end
        end
    end

    assign o_q = r_q[OB];

endmodule

`default_nettype wire

/* rtl/core/lsd_geom.sv */
// ============================================================================
// lsd_geom
// base selection, projections and cross products, eight register stages
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lsd_geom #(
    parameter int CW = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic signed [CW-1:0] i_pt [8],
    output logic          [2*CW+2:0]  o_c0,
    output logic          [2*CW+2:0]  o_c1,
    output logic          [2*CW+3:0]  o_ds,
    output logic          [2*CW+2:0]  o_pmin,
    output logic          [2*CW+2:0]  o_tm,
    output logic          [2*CW+1:0]  o_l2,
    output lsd_pkg::t_flags           o_flags
);

    localparam int DW = CW + 1;
    localparam int LW = 2 * DW;
    localparam int MW = 2 * DW + 1;

    // stage 1: differences
    logic                 r_v1, r_v2, r_v3;
    logic signed [CW-1:0] r_pt1 [8];
    logic signed [DW-1:0] r_d1  [4];
    // stage 2: squares
    logic signed [CW-1:0] r_pt2 [8];
    logic signed [DW-1:0] r_d2  [4];
    logic signed [LW-1:0] r_sq2 [4];
    // stage 3: squared lengths
    logic signed [CW-1:0] r_pt3 [8];
    logic signed [DW-1:0] r_d3  [4];
    logic        [LW-1:0] r_la3, r_lb3;
    // stage 4: base selection
    lsd_pkg::t_flags      r_f4, r_f5, r_f6, r_f7, r_f8;
    logic signed [DW-1:0] r_v4  [2];
    logic signed [DW-1:0] r_w4  [4];
    logic signed [DW-1:0] r_o4  [2];
    logic        [LW-1:0] r_l24, r_l25, r_l26, r_l27, r_l28;
    logic signed [CW-1:0] n_sx, n_sy, n_p0x, n_p0y, n_p1x, n_p1y;
    logic                 n_sel_a;
    // stage 5: products
    logic signed [LW-1:0] r_pr5 [10];
    // stage 6: dot and cross sums
    logic signed [MW-1:0] r_dot6 [2];
    logic signed [MW-1:0] r_cr6  [3];
    // stage 7: magnitudes
    logic        [MW-1:0] r_c7  [3];
    logic        [MW-1:0] r_pn7 [2];
    logic        [MW-1:0] n_c   [3];
    logic        [MW-1:0] n_pn  [2];
    // stage 8: outputs
    logic        [MW-1:0] r_c08, r_c18, r_pm8, r_tm8;
    logic        [MW:0]   r_ds8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_f4 <= '0;
            r_f5 <= '0;
            r_f6 <= '0;
            r_f7 <= '0;
            r_f8 <= '0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_f4 <= '{valid: r_v3, degen: (r_la3 == '0) || (r_lb3 == '0), pzero: 1'b0};
            r_f5 <= r_f4;
            r_f6 <= r_f5;
            r_f7 <= r_f6;
            r_f8 <= '{valid: r_f7.valid, degen: r_f7.degen,
                      pzero: (r_c7[0] == '0) && (r_c7[1] == '0)};
        end
    end

    always_comb begin
        n_sel_a = (r_la3 > r_lb3);
        n_sx    = n_sel_a ? r_pt3[0] : r_pt3[4];
        n_sy    = n_sel_a ? r_pt3[1] : r_pt3[5];
        n_p0x   = n_sel_a ? r_pt3[4] : r_pt3[0];
        n_p0y   = n_sel_a ? r_pt3[5] : r_pt3[1];
        n_p1x   = n_sel_a ? r_pt3[6] : r_pt3[2];
        n_p1y   = n_sel_a ? r_pt3[7] : r_pt3[3];
    end

    always_comb begin
        logic signed [MW:0] twice;
        logic signed [MW:0] l2e;
        logic signed [MW:0] de;
        logic        [MW:0] mde;
        logic        [MW-1:0] mdot;
        logic                 near;
        for (int k = 0; k < 3; k++) begin
            n_c[k] = r_cr6[k][MW-1] ? (~r_cr6[k] + 1'b1) : r_cr6[k];
        end
        for (int k = 0; k < 2; k++) begin
            twice = {r_dot6[k], 1'b0};
            l2e   = {2'b00, r_l26};
            de    = {r_dot6[k][MW-1], r_dot6[k]} - l2e;
            mde   = de[MW] ? (~de + 1'b1) : de;
            mdot  = r_dot6[k][MW-1] ? (~r_dot6[k] + 1'b1) : r_dot6[k];
            near  = r_dot6[k][MW-1] || (twice < l2e);
            n_pn[k] = near ? mdot : mde[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt1 <= i_pt;
            r_d1[0] <= DW'(i_pt[2]) - DW'(i_pt[0]);
            r_d1[1] <= DW'(i_pt[3]) - DW'(i_pt[1]);
            r_d1[2] <= DW'(i_pt[6]) - DW'(i_pt[4]);
            r_d1[3] <= DW'(i_pt[7]) - DW'(i_pt[5]);

            r_pt2 <= r_pt1;
            r_d2  <= r_d1;
            for (int k = 0; k < 4; k++) begin
                r_sq2[k] <= r_d1[k] * r_d1[k];
            end

            r_pt3 <= r_pt2;
            r_d3  <= r_d2;
            r_la3 <= r_sq2[0] + r_sq2[1];
            r_lb3 <= r_sq2[2] + r_sq2[3];

            r_v4[0] <= n_sel_a ? r_d3[0] : r_d3[2];
            r_v4[1] <= n_sel_a ? r_d3[1] : r_d3[3];
            r_l24   <= n_sel_a ? r_la3 : r_lb3;
            r_w4[0] <= DW'(n_p0x) - DW'(n_sx);
            r_w4[1] <= DW'(n_p0y) - DW'(n_sy);
            r_w4[2] <= DW'(n_p1x) - DW'(n_sx);
            r_w4[3] <= DW'(n_p1y) - DW'(n_sy);
            r_o4[0] <= DW'(n_p1x) - DW'(n_p0x);
            r_o4[1] <= DW'(n_p1y) - DW'(n_p0y);

            for (int k = 0; k < 2; k++) begin
                r_pr5[4*k]   <= r_w4[2*k]   * r_v4[0];
                r_pr5[4*k+1] <= r_w4[2*k+1] * r_v4[1];
                r_pr5[4*k+2] <= r_v4[0] * r_w4[2*k+1];
                r_pr5[4*k+3] <= r_v4[1] * r_w4[2*k];
            end
            r_pr5[8] <= r_v4[0] * r_o4[1];
            r_pr5[9] <= r_v4[1] * r_o4[0];
            r_l25    <= r_l24;

            r_dot6[0] <= r_pr5[0] + r_pr5[1];
            r_dot6[1] <= r_pr5[4] + r_pr5[5];
            r_cr6[0]  <= r_pr5[2] - r_pr5[3];
            r_cr6[1]  <= r_pr5[6] - r_pr5[7];
            r_cr6[2]  <= r_pr5[8] - r_pr5[9];
            r_l26     <= r_l25;

            r_c7  <= n_c;
            r_pn7 <= n_pn;
            r_l27 <= r_l26;

            r_c08 <= r_c7[0];
            r_c18 <= r_c7[1];
            r_tm8 <= r_c7[2];
            r_ds8 <= {1'b0, r_c7[0]} + {1'b0, r_c7[1]};
            r_pm8 <= (r_pn7[0] < r_pn7[1]) ? r_pn7[0] : r_pn7[1];
            r_l28 <= r_l27;
        end
    end

    assign o_c0    = r_c08;
    assign o_c1    = r_c18;
    assign o_ds    = r_ds8;
    assign o_pmin  = r_pm8;
    assign o_tm    = r_tm8;
    assign o_l2    = r_l28;
    assign o_flags = r_f8;

endmodule

`default_nettype wire

/* rtl/core/line_segment_distance_triplet.sv */
// ============================================================================
// line_segment_distance_triplet
// perpendicular, parallel and angle distances of two 2-D segments
// ============================================================================
//  channel  valid    ready    payload
//  in       i_valid  o_ready  i_a_*, i_b_* segment endpoints
//  out      o_valid  i_ready  o_perp_dist, o_par_dist, o_ang_dist
//
//  one segment pair per cycle while o_ready is high; path to the output register:
//  (8 geometry stages, 5 multiply stages, 26 root-search stages, output reg)
//  the bit-serial root search sets the depth
//  a skid register behind the output keeps input open while a result waits
//  reset clears valid and flag bits and the delay-line registers only
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module line_segment_distance_triplet #(
    parameter int COORD_BITS = lsd_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lsd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [COORD_BITS-1:0] i_a_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_a_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_a_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_a_end_y,
    input  wire logic signed [COORD_BITS-1:0] i_b_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_b_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_b_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_b_end_y,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [lsd_pkg::OUT_BITS-1:0]      o_perp_dist,
    output logic [lsd_pkg::OUT_BITS-1:0]      o_par_dist,
    output logic [lsd_pkg::OUT_BITS-1:0]      o_ang_dist
);

    localparam int OB  = lsd_pkg::OUT_BITS;
    localparam int DW  = COORD_BITS + 1;
    localparam int LW  = 2 * DW;
    localparam int MW  = 2 * DW + 1;
    localparam int SW  = 2 * MW + 1;
    localparam int F2  = 2 * FRAC_BITS;
    localparam int NW  = 2 * SW + F2;
    localparam int DDW = 2 * MW + 2 + LW;
    localparam int FW  = $bits(lsd_pkg::t_flags);
    localparam int LAT = 5 + OB + 1;

    logic                        en;
    logic signed [COORD_BITS-1:0] pt [8];
    logic [MW-1:0]               g_c0, g_c1, g_pmin, g_tm;
    logic [MW:0]                 g_ds;
    logic [LW-1:0]               g_l2;
    lsd_pkg::t_flags             g_flags;
    logic [FW-1:0]               fl_bits;
    lsd_pkg::t_flags             fl;

    logic [2*MW-1:0]             c0sq, c1sq, pmsq, tmsq;
    logic [2*MW+1:0]             dsq;
    logic [SW-1:0]               r_s;
    logic [2*MW+1:0]             r_dsq;
    logic [LW-1:0]               l3, l5;
    logic [4*MW-1:0]             sq5;
    logic [2*SW-1:0]             np;
    logic [DDW-1:0]              dp;
    logic [OB-1:0]               q_perp, q_par, q_ang;

    logic                        push;
    logic [3*OB-1:0]             n_res;
    logic                        r_out_valid, r_skid_valid;
    logic [3*OB-1:0]             r_out, r_skid;

    assign en      = !r_skid_valid;
    assign o_ready = en;

    assign pt[0] = i_a_start_x;
    assign pt[1] = i_a_start_y;
    assign pt[2] = i_a_end_x;
    assign pt[3] = i_a_end_y;
    assign pt[4] = i_b_start_x;
    assign pt[5] = i_b_start_y;
    assign pt[6] = i_b_end_x;
    assign pt[7] = i_b_end_y;

    lsd_geom #(.CW(COORD_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_pt    (pt),
        .o_c0    (g_c0),
        .o_c1    (g_c1),
        .o_ds    (g_ds),
        .o_pmin  (g_pmin),
        .o_tm    (g_tm),
        .o_l2    (g_l2),
        .o_flags (g_flags)
    );

    lsd_mul #(.AW(MW), .BW(MW)) u_mul_c0 (
        .i_clk(i_clk), .i_en(en), .i_a(g_c0), .i_b(g_c0), .o_p(c0sq)
    );
    lsd_mul #(.AW(MW), .BW(MW)) u_mul_c1 (
        .i_clk(i_clk), .i_en(en), .i_a(g_c1), .i_b(g_c1), .o_p(c1sq)
    );
    lsd_mul #(.AW(MW+1), .BW(MW+1)) u_mul_ds (
        .i_clk(i_clk), .i_en(en), .i_a(g_ds), .i_b(g_ds), .o_p(dsq)
    );
    lsd_mul #(.AW(MW), .BW(MW)) u_mul_pm (
        .i_clk(i_clk), .i_en(en), .i_a(g_pmin), .i_b(g_pmin), .o_p(pmsq)
    );
    lsd_mul #(.AW(MW), .BW(MW)) u_mul_tm (
        .i_clk(i_clk), .i_en(en), .i_a(g_tm), .i_b(g_tm), .o_p(tmsq)
    );

    lsd_dly #(.W(LW), .DEPTH(3)) u_dly_l3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(g_l2), .o_d(l3)
    );
    lsd_dly #(.W(LW), .DEPTH(2)) u_dly_l5 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(l3), .o_d(l5)
    );
    lsd_dly #(.W(4*MW), .DEPTH(3)) u_dly_sq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d({pmsq, tmsq}), .o_d(sq5)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s   <= {1'b0, c0sq} + {1'b0, c1sq};
            r_dsq <= dsq;
        end
    end

    lsd_mul #(.AW(SW), .BW(SW)) u_mul_np (
        .i_clk(i_clk), .i_en(en), .i_a(r_s), .i_b(r_s), .o_p(np)
    );
    lsd_mul #(.AW(2*MW+2), .BW(LW)) u_mul_dp (
        .i_clk(i_clk), .i_en(en), .i_a(r_dsq), .i_b(l3), .o_p(dp)
    );

    lsd_isq #(.NW(NW), .DDW(DDW), .OB(OB)) u_isq_perp (
        .i_clk(i_clk), .i_en(en), .i_n({np, {F2{1'b0}}}), .i_d(dp), .o_q(q_perp)
    );
    lsd_isq #(.NW(NW), .DDW(DDW), .OB(OB)) u_isq_par (
        .i_clk(i_clk), .i_en(en), .i_n(NW'({sq5[4*MW-1:2*MW], {F2{1'b0}}})),
        .i_d(DDW'(l5)), .o_q(q_par)
    );
    lsd_isq #(.NW(NW), .DDW(DDW), .OB(OB)) u_isq_ang (
        .i_clk(i_clk), .i_en(en), .i_n(NW'({sq5[2*MW-1:0], {F2{1'b0}}})),
        .i_d(DDW'(l5)), .o_q(q_ang)
    );

    lsd_dly #(.W(FW), .DEPTH(LAT)) u_dly_flags (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(g_flags), .o_d(fl_bits)
    );

    assign fl   = lsd_pkg::t_flags'(fl_bits);
    assign push = en && fl.valid;

    always_comb begin
        n_res = '0;
        if (!fl.degen) begin
            n_res[3*OB-1:2*OB] = fl.pzero ? '0 : q_perp;
            n_res[2*OB-1:OB]   = q_par;
            n_res[OB-1:0]      = q_ang;
        end
    end

    // output register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            if (!r_out_valid || i_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid && i_ready) begin
            r_skid_valid <= 1'b0;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            if (!r_out_valid || i_ready) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (r_skid_valid && i_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_perp_dist = r_out[3*OB-1:2*OB];
    assign o_par_dist  = r_out[2*OB-1:OB];
    assign o_ang_dist  = r_out[OB-1:0];

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready && push))
        else $error("skid filled without a blocked transfer");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid result lost while output stalled");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && fl.valid) |=> $stable(fl_bits))
        else $error("pipeline moved while skid full");
`endif

endmodule

`default_nettype wire
